>>> rtl/gauss_exp_tail_density_macros.svh
// Assertion macros shared by the density pipeline RTL.
`ifndef GAUSS_EXP_TAIL_DENSITY_MACROS_SVH
`define GAUSS_EXP_TAIL_DENSITY_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante
`define GEXP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gexp: same-cycle check failed");
// Check cons in the cycle after ante
`define GEXP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gexp: next-cycle check failed");
`else
`define GEXP_ASSERT_SAME(lbl, ante, cons)
`define GEXP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/gexp_pkg.sv
// Package: shared types, constants and exp tables of the density pipeline.
`timescale 1ns / 1ps
package gexp_pkg;

    localparam int POS_W     = 32;
    localparam int DENS_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int MVAL_W    = 20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MEAN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_START = 2'd2;

    localparam logic [POS_W-1:0] INV_WIDTH_RESET = 32'h0001_0000;

    // Product saturation level and exp cutoff
    localparam logic [63:0] MUL_CAP = 64'h4000_0000_0000_0000;
    localparam logic [63:0] EXP_CAP = 64'h0000_0100_0000_0000;

    localparam logic [24:0] Q24_ONE      = 25'h100_0000;
    localparam logic [3:0]  EXP_INT_LAST = 4'd11;
    localparam logic [17:0] DIV6_MUL     = 18'd174763;
    localparam logic [25:0] ROUND_HALF   = 26'd128;
    localparam logic [DENS_W-1:0] DENS_ONE = 17'h1_0000;

    typedef struct packed {
        logic in_tail;
        logic is_one;
        logic is_zero;
    } exp_flags_t;

    typedef struct packed {
        exp_flags_t              flags;
        logic [MVAL_W-1:0]       mval;
    } exp_req_t;

    // exp(-i) in Q.24 for integer part i
    function automatic logic [24:0] exp_int(input logic [3:0] idx);
        logic [24:0] val;
        case (idx)
            4'd0:    val = 25'd16777216;
            4'd1:    val = 25'd6171993;
            4'd2:    val = 25'd2270549;
            4'd3:    val = 25'd835288;
            4'd4:    val = 25'd307285;
            4'd5:    val = 25'd113044;
            4'd6:    val = 25'd41587;
            4'd7:    val = 25'd15299;
            4'd8:    val = 25'd5628;
            4'd9:    val = 25'd2070;
            4'd10:   val = 25'd762;
            4'd11:   val = 25'd280;
            default: val = 25'd0;
        endcase
        return val;
    endfunction

    // exp(-j/8) in Q.24
    function automatic logic [24:0] exp_eighth(input logic [2:0] idx);
        logic [24:0] val;
        case (idx)
            3'd0:    val = 25'd16777216;
            3'd1:    val = 25'd14805841;
            3'd2:    val = 25'd13066109;
            3'd3:    val = 25'd11530801;
            3'd4:    val = 25'd10175896;
            3'd5:    val = 25'd8980197;
            3'd6:    val = 25'd7924996;
            default: val = 25'd6993784;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/gexp_if.sv
// Interfaces: sample, result and configuration channels.
`timescale 1ns / 1ps
interface gexp_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [gexp_pkg::POS_W-1:0]   sample_pos;

    modport source (output valid, output sample_pos, input ready);
    modport sink   (input valid, input sample_pos, output ready);
endinterface

interface gexp_result_if;
    logic                          valid;
    logic                          ready;
    logic [gexp_pkg::DENS_W-1:0]   density;
    logic                          in_tail;

    modport source (output valid, output density, output in_tail, input ready);
    modport sink   (input valid, input density, input in_tail, output ready);
endinterface

interface gexp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [gexp_pkg::CFG_IDX_W-1:0]   index;
    logic [gexp_pkg::POS_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/gexp_exp_unit.sv
// Six-stage exp(-M) evaluator: tables, cubic correction, rounding, output register.
`timescale 1ns / 1ps
module gexp_exp_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gexp_pkg::exp_req_t  in_req,
    gexp_result_if.source       result
);

    logic t1_valid_reg, t2_valid_reg, t3_valid_reg;
    logic t4_valid_reg, t5_valid_reg, t6_valid_reg;
    logic t1_en, t2_en, t3_en, t4_en, t5_en, t6_en;

    gexp_pkg::exp_flags_t t1_flags_reg, t2_flags_reg, t3_flags_reg;
    gexp_pkg::exp_flags_t t4_flags_reg, t5_flags_reg;

    logic [24:0] t1_e1_reg, t2_e1_reg, t3_e1_reg, t4_e1_reg;
    logic [20:0] t1_r_reg, t2_r_reg, t3_r_reg;
    logic [17:0] t1_r2_reg, t2_r2_reg, t3_r2_reg;
    logic [14:0] t2_r3_reg;
    logic [12:0] t3_q6_reg;
    logic [24:0] t4_poly_reg;
    logic [24:0] t5_e_reg;
    logic [gexp_pkg::DENS_W-1:0] t6_dens_reg;
    logic                        t6_tail_reg;

    logic [3:0]  ip;
    logic [2:0]  jdx;
    logic [20:0] r_next;
    logic [48:0] tab_prod;
    logic [41:0] r_sq;
    logic [38:0] r_cube;
    logic [32:0] q6_prod;
    logic [25:0] poly_full;
    logic [49:0] e_prod;
    logic [25:0] e_round;
    logic [17:0] e_shift;
    logic [gexp_pkg::DENS_W-1:0] dens_next;

    // Advance a stage when it is empty or its successor moves
    assign t6_en    = !t6_valid_reg || result.ready;
    assign t5_en    = !t5_valid_reg || t6_en;
    assign t4_en    = !t4_valid_reg || t5_en;
    assign t3_en    = !t3_valid_reg || t4_en;
    assign t2_en    = !t2_valid_reg || t3_en;
    assign t1_en    = !t1_valid_reg || t2_en;
    assign in_ready = t1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
            t6_valid_reg <= 1'b0;
        end
        else
        begin
            if (t1_en) t1_valid_reg <= in_valid;
            if (t2_en) t2_valid_reg <= t1_valid_reg;
            if (t3_en) t3_valid_reg <= t2_valid_reg;
            if (t4_en) t4_valid_reg <= t3_valid_reg;
            if (t5_en) t5_valid_reg <= t4_valid_reg;
            if (t6_en) t6_valid_reg <= t5_valid_reg;
        end
    end

    // Split M into integer, eighth and remainder; look up the table product
    always_comb
    begin
        ip       = in_req.mval[19:16];
        jdx      = in_req.mval[15:13];
        r_next   = {in_req.mval[12:0], 8'b0};
        tab_prod = 49'(gexp_pkg::exp_int(ip)) * 49'(gexp_pkg::exp_eighth(jdx));
        r_sq     = 42'(r_next) * 42'(r_next);
    end

    // Cube term, division by six, polynomial and scaling
    always_comb
    begin
        r_cube    = 39'(t1_r2_reg) * 39'(t1_r_reg);
        q6_prod   = 33'(t2_r3_reg) * 33'(gexp_pkg::DIV6_MUL);
        poly_full = 26'(gexp_pkg::Q24_ONE) - 26'(t3_r_reg) + 26'(t3_r2_reg[17:1])
                    - 26'(t3_q6_reg);
        e_prod    = 50'(t4_e1_reg) * 50'(t4_poly_reg);
    end

    // Round to Q1.16 and apply the saturated cases
    always_comb
    begin
        e_round = 26'(t5_e_reg) + gexp_pkg::ROUND_HALF;
        e_shift = e_round[25:8];
        if (t5_flags_reg.is_one)
            dens_next = gexp_pkg::DENS_ONE;
        else if (t5_flags_reg.is_zero)
            dens_next = '0;
        else if (e_shift > 18'(gexp_pkg::DENS_ONE))
            dens_next = gexp_pkg::DENS_ONE;
        else
            dens_next = e_shift[16:0];
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (t1_en)
        begin
            t1_flags_reg <= in_req.flags;
            t1_e1_reg    <= tab_prod[48:24];
            t1_r_reg     <= r_next;
            t1_r2_reg    <= r_sq[41:24];
        end
        if (t2_en)
        begin
            t2_flags_reg <= t1_flags_reg;
            t2_e1_reg    <= t1_e1_reg;
            t2_r_reg     <= t1_r_reg;
            t2_r2_reg    <= t1_r2_reg;
            t2_r3_reg    <= r_cube[38:24];
        end
        if (t3_en)
        begin
            t3_flags_reg <= t2_flags_reg;
            t3_e1_reg    <= t2_e1_reg;
            t3_r_reg     <= t2_r_reg;
            t3_r2_reg    <= t2_r2_reg;
            t3_q6_reg    <= q6_prod[32:20];
        end
        if (t4_en)
        begin
            t4_flags_reg <= t3_flags_reg;
            t4_e1_reg    <= t3_e1_reg;
            t4_poly_reg  <= poly_full[24:0];
        end
        if (t5_en)
        begin
            t5_flags_reg <= t4_flags_reg;
            t5_e_reg     <= e_prod[48:24];
        end
        if (t6_en)
        begin
            t6_dens_reg <= dens_next;
            t6_tail_reg <= t5_flags_reg.in_tail;
        end
    end

    assign result.valid   = t6_valid_reg;
    assign result.density = t6_dens_reg;
    assign result.in_tail = t6_tail_reg;

endmodule

>>> rtl/gauss_exp_tail_density.sv
// Top level: Gaussian with exponential lower tail, exponent pipeline and exp unit.
// Pipeline: twelve register stages (six exponent, six exp).
// Throughput: one sample per cycle while result.ready holds; a stage advances when it
// is empty or its successor moves.
// Reset clears all valid bits and loads mean 0, reciprocal width 1.0 and transition 0.
`timescale 1ns / 1ps
`include "gauss_exp_tail_density_macros.svh"
module gauss_exp_tail_density
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    gexp_sample_if.sink   sample,
    gexp_result_if.source result,
    gexp_cfg_if.sink      cfg
);

    // Scaled-product width, halved-square width, exponent width, Q16 alignment
    localparam int ZW  = 63 - FRAC_BITS;
    localparam int XW  = ZW - 32;
    localparam int HW  = ZW - 1;
    localparam int MW  = ZW + 1;
    localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHL = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

    logic signed [31:0] peak_mean_reg;
    logic        [31:0] inv_width_reg;
    logic signed [31:0] tail_start_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic s1_en, s2_en, s3_en, s4_en, s5_en, s6_en;
    logic exp_ready;

    logic [31:0]   s1_a1_reg, s1_a2_reg;
    logic          s1_tail_reg, s1_dpos_reg;
    logic [63:0]   s2_p1_reg, s2_p2_reg;
    logic          s2_tail_reg, s2_dpos_reg;
    logic [ZW-1:0] s3_z_reg, s3_u_reg;
    logic          s3_tail_reg, s3_dpos_reg;
    logic [63:0]   s4_sq_reg, s4_ll_reg;
    logic [ZW-1:0] s4_cross_reg;
    logic          s4_uvsat_reg, s4_tail_reg, s4_dpos_reg;
    logic [HW-1:0] s5_h_reg;
    logic [ZW-1:0] s5_p_reg;
    logic          s5_tail_reg, s5_dpos_reg;
    gexp_pkg::exp_req_t s6_req_reg;

    logic signed [32:0] d_xm, d_xt, d_tm;
    logic [31:0]   a1_next, a2_next;
    logic          tail_next, dpos_next;
    logic [63:0]   c1, c2;
    logic [ZW-1:0] q_sel;
    logic [31:0]   q_clamp;
    logic [XW-1:0] u_hi, v_hi, x_hi;
    logic [31:0]   x_lo;
    logic [63:0]   sq_next, ll_next;
    logic [ZW-1:0] cross_next;
    logic [64:0]   uv_sum;
    logic          uv_over;
    logic [63:0]   uv_cap;
    logic [MW-1:0] m_sum;
    logic [63:0]   m64, m16;
    gexp_pkg::exp_req_t req_next;

    function automatic logic [31:0] mag33(input logic signed [32:0] d);
        logic signed [32:0] n;
        n = d[32] ? -d : d;
        return n[31:0];
    endfunction

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_mean_reg  <= '0;
            inv_width_reg  <= gexp_pkg::INV_WIDTH_RESET;
            tail_start_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                gexp_pkg::REG_PEAK_MEAN:  peak_mean_reg  <= cfg.data;
                gexp_pkg::REG_INV_WIDTH:  inv_width_reg  <= cfg.data;
                gexp_pkg::REG_TAIL_START: tail_start_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or its successor moves
    assign s6_en        = !s6_valid_reg || exp_ready;
    assign s5_en        = !s5_valid_reg || s6_en;
    assign s4_en        = !s4_valid_reg || s5_en;
    assign s3_en        = !s3_valid_reg || s4_en;
    assign s2_en        = !s2_valid_reg || s3_en;
    assign s1_en        = !s1_valid_reg || s2_en;
    assign sample.ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en) s1_valid_reg <= sample.valid;
            if (s2_en) s2_valid_reg <= s1_valid_reg;
            if (s3_en) s3_valid_reg <= s2_valid_reg;
            if (s4_en) s4_valid_reg <= s3_valid_reg;
            if (s5_en) s5_valid_reg <= s4_valid_reg;
            if (s6_en) s6_valid_reg <= s5_valid_reg;
        end
    end

    // Stage 1: pick the branch and form distance magnitudes
    always_comb
    begin
        d_xm      = 33'(sample.sample_pos) - 33'(peak_mean_reg);
        d_xt      = 33'(sample.sample_pos) - 33'(tail_start_reg);
        d_tm      = 33'(tail_start_reg) - 33'(peak_mean_reg);
        tail_next = sample.sample_pos <= tail_start_reg;
        dpos_next = d_tm > 33'sd0;
        a1_next   = tail_next ? mag33(d_xt) : mag33(d_xm);
        a2_next   = mag33(d_tm);
    end

    // Stage 3: saturate the width products and drop fraction bits
    always_comb
    begin
        c1 = (s2_p1_reg > gexp_pkg::MUL_CAP) ? gexp_pkg::MUL_CAP : s2_p1_reg;
        c2 = (s2_p2_reg > gexp_pkg::MUL_CAP) ? gexp_pkg::MUL_CAP : s2_p2_reg;
    end

    // Stage 4: square and the split u*v partial products
    always_comb
    begin
        q_sel      = s3_tail_reg ? s3_u_reg : s3_z_reg;
        q_clamp    = (|q_sel[ZW-1:31]) ? 32'h8000_0000 : q_sel[31:0];
        sq_next    = 64'(q_clamp) * 64'(q_clamp);
        u_hi       = s3_u_reg[ZW-1:32];
        v_hi       = s3_z_reg[ZW-1:32];
        x_hi       = (|u_hi) ? u_hi : v_hi;
        x_lo       = (|u_hi) ? s3_z_reg[31:0] : s3_u_reg[31:0];
        cross_next = ZW'(x_hi) * ZW'(x_lo);
        ll_next    = 64'(s3_u_reg[31:0]) * 64'(s3_z_reg[31:0]);
    end

    // Stage 5: join the partial products and saturate
    always_comb
    begin
        uv_sum  = 65'(s4_ll_reg) + 65'({s4_cross_reg[29:0], 32'b0});
        uv_over = s4_uvsat_reg || (|s4_cross_reg[ZW-1:30])
                  || (uv_sum > 65'(gexp_pkg::MUL_CAP));
        uv_cap  = uv_over ? gexp_pkg::MUL_CAP : uv_sum[63:0];
    end

    // Stage 6: negated exponent, Q16 alignment and range flags
    always_comb
    begin
        if (!s5_tail_reg)
            m_sum = MW'(s5_h_reg);
        else if (s5_dpos_reg)
            m_sum = MW'(s5_h_reg) - MW'(s5_p_reg);
        else
            m_sum = MW'(s5_h_reg) + MW'(s5_p_reg);
        m64 = 64'(m_sum[ZW-1:0]);
        m16 = (m64 >> SHR) << SHL;
        req_next.flags.in_tail = s5_tail_reg;
        req_next.flags.is_one  = m_sum[MW-1] || (m_sum == '0);
        req_next.flags.is_zero = (m64 > gexp_pkg::EXP_CAP)
                                 || (m16[63:16] > 48'(gexp_pkg::EXP_INT_LAST));
        req_next.mval          = m16[gexp_pkg::MVAL_W-1:0];
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_a1_reg   <= a1_next;
            s1_a2_reg   <= a2_next;
            s1_tail_reg <= tail_next;
            s1_dpos_reg <= dpos_next;
        end
        if (s2_en)
        begin
            s2_p1_reg   <= 64'(s1_a1_reg) * 64'(inv_width_reg);
            s2_p2_reg   <= 64'(s1_a2_reg) * 64'(inv_width_reg);
            s2_tail_reg <= s1_tail_reg;
            s2_dpos_reg <= s1_dpos_reg;
        end
        if (s3_en)
        begin
            s3_z_reg    <= c1[62:FRAC_BITS];
            s3_u_reg    <= c2[62:FRAC_BITS];
            s3_tail_reg <= s2_tail_reg;
            s3_dpos_reg <= s2_dpos_reg;
        end
        if (s4_en)
        begin
            s4_sq_reg    <= sq_next;
            s4_ll_reg    <= ll_next;
            s4_cross_reg <= cross_next;
            s4_uvsat_reg <= (|u_hi) && (|v_hi);
            s4_tail_reg  <= s3_tail_reg;
            s4_dpos_reg  <= s3_dpos_reg;
        end
        if (s5_en)
        begin
            s5_h_reg    <= s4_sq_reg[62:FRAC_BITS+1];
            s5_p_reg    <= uv_cap[62:FRAC_BITS];
            s5_tail_reg <= s4_tail_reg;
            s5_dpos_reg <= s4_dpos_reg;
        end
        if (s6_en)
        begin
            s6_req_reg <= req_next;
        end
    end

    gexp_exp_unit u_exp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s6_valid_reg),
        .in_ready (exp_ready),
        .in_req   (s6_req_reg),
        .result   (result)
    );

    `GEXP_ASSERT_SAME(a_dens_range, result.valid, result.density <= gexp_pkg::DENS_ONE)
    `GEXP_ASSERT_NEXT(a_accept_lands, sample.valid && sample.ready, s1_valid_reg)
    `GEXP_ASSERT_NEXT(a_exp_stall_holds, s6_valid_reg && !exp_ready, s6_valid_reg && $stable(s6_req_reg))
    `GEXP_ASSERT_SAME(a_gauss_sign, s5_valid_reg && !s5_tail_reg, req_next.flags.is_one == (s5_h_reg == '0))

endmodule
